### rtl/core/mrfc_pkg.sv
package mrfc_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 50;
  localparam int unsigned IdxW = $clog2(MAX_FRAME_BYTES + 1);

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] REG_EXPECTED_ADDR = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] REG_EXPECTED_KIND = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] REG_EXPECTED_REG  = CfgIdxW'(2);

  typedef enum logic [1:0] {
    KIND_MEAS     = 2'd0,
    KIND_SETTINGS = 2'd1,
    KIND_FIRMWARE = 2'd2,
    KIND_ECHO     = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FRAME = 2'd1,
    ST_CRC   = 2'd2,
    ST_REG   = 2'd3
  } status_e;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [IdxW-1:0] LEN_MEAS     = IdxW'(23);
  localparam logic [IdxW-1:0] LEN_SETTINGS = IdxW'(33);
  localparam logic [IdxW-1:0] LEN_FIRMWARE = IdxW'(19);
  localparam logic [IdxW-1:0] LEN_ECHO     = IdxW'(8);

  localparam logic [7:0] COUNT_MEAS     = 8'd18;
  localparam logic [7:0] COUNT_SETTINGS = 8'd28;
  localparam logic [7:0] COUNT_FIRMWARE = 8'd14;
  localparam logic [7:0] FUNC_WRITE_SINGLE = 8'h06;

  typedef struct packed {
    logic       hit;
    logic [1:0] sel;
  } slot_t;

  function automatic logic [15:0] crc_fold(logic [15:0] crc_in, logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // slot of the word whose low byte sits at this index
  function automatic slot_t word_slot(kind_e kind, logic [IdxW-1:0] idx);
    slot_t s;
    s = '0;
    case (kind)
      KIND_MEAS: begin
        if (idx == IdxW'(4)) s = '{hit: 1'b1, sel: 2'd0};
        if (idx == IdxW'(6)) s = '{hit: 1'b1, sel: 2'd1};
        if (idx == IdxW'(8)) s = '{hit: 1'b1, sel: 2'd2};
      end
      KIND_SETTINGS: begin
        if (idx == IdxW'(6))  s = '{hit: 1'b1, sel: 2'd0};
        if (idx == IdxW'(8))  s = '{hit: 1'b1, sel: 2'd1};
        if (idx == IdxW'(10)) s = '{hit: 1'b1, sel: 2'd2};
        if (idx == IdxW'(16)) s = '{hit: 1'b1, sel: 2'd3};
      end
      KIND_FIRMWARE: begin
        if (idx == IdxW'(16)) s = '{hit: 1'b1, sel: 2'd0};
      end
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

### rtl/core/mrfc_ifs.sv
interface mrfc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface mrfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mrfc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] value_a;
  logic [15:0] value_b;
  logic [15:0] value_c;
  logic [15:0] value_d;
  modport source (output valid, output status, output value_a, output value_b,
                  output value_c, output value_d, input ready);
  modport sink (input valid, input status, input value_a, input value_b,
                input value_c, input value_d, output ready);
endinterface

### rtl/core/modbus_response_frame_checker.sv
// Modbus RTU response frame checker.
// in_i takes the received frame one byte per item, last_byte marking the end.
// cfg_i writes expected_addr (0), expected_kind (1) and expected_reg (2);
// other indexes are accepted and ignored. Write only while no frame is open.
// out_o gives one item per frame: status and up to four captured words.
// Throughput: one byte per cycle while in_i.ready is high. A byte is
// registered on acceptance, then folded into the frame state, the CRC two
// bytes behind; a frame's last byte loads the registered result on out_o.
// The CRC is a byte-wide unrolled fold, one byte per clock.
// While a result waits on out_o, non-final bytes keep flowing; only a final
// byte waits in the input register, and then in_i.ready drops until out_o
// is taken.
// Reset clears the configuration to zero, empties both registers and starts
// a fresh frame (CRC 0xFFFF, byte count zero). Bytes past 50 in a frame are
// dropped; the frame is judged on its first 50 bytes.
module modbus_response_frame_checker (
  input logic clk_i,
  input logic rst_ni,
  mrfc_cfg_if.sink cfg_i,
  mrfc_in_if.sink in_i,
  mrfc_out_if.source out_o
);
  import mrfc_pkg::*;

  logic [7:0]  addr_q;
  kind_e       kind_q;
  logic [15:0] reg_q;

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;

  logic [15:0]     crc_q, crc_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [7:0]      tail0_q, tail0_d, tail1_q, tail1_d;
  logic            hdr_q, hdr_d;
  logic [15:0]     words_q [4];
  logic [15:0]     words_d [4];
  logic [15:0]     echo_q, echo_d;
  logic [7:0]      part_q, part_d;

  logic            out_valid_q;
  status_e         status_q, status_d;
  logic [15:0]     va_q, vb_q, vc_q, vd_q;
  logic [15:0]     va_d, vb_d, vc_d, vd_d;

  logic            out_free, s1_adv, take;
  logic [IdxW-1:0] want_len;
  slot_t           slot;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      kind_q <= KIND_MEAS;
      reg_q  <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_EXPECTED_ADDR: addr_q <= cfg_i.data[7:0];
        REG_EXPECTED_KIND: kind_q <= kind_e'(cfg_i.data[1:0]);
        REG_EXPECTED_REG:  reg_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_adv     = s1_valid_q && (!s1_last_q || out_free);
  assign in_i.ready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_byte_q <= in_i.data_byte;
      s1_last_q <= in_i.last_byte;
    end
  end

  always_comb begin
    take    = idx_q < IdxW'(MAX_FRAME_BYTES);
    crc_d   = crc_q;
    idx_d   = idx_q;
    tail0_d = tail0_q;
    tail1_d = tail1_q;
    hdr_d   = hdr_q;
    words_d = words_q;
    echo_d  = echo_q;
    part_d  = part_q;
    slot    = word_slot(kind_q, idx_q);
    if (take) begin
      if (idx_q >= IdxW'(2)) begin
        crc_d = crc_fold(crc_q, tail0_q);
      end
      tail0_d = tail1_q;
      tail1_d = s1_byte_q;
      if (idx_q == IdxW'(0) && s1_byte_q != addr_q) begin
        hdr_d = 1'b0;
      end
      if (idx_q == IdxW'(1) && kind_q == KIND_ECHO && s1_byte_q != FUNC_WRITE_SINGLE) begin
        hdr_d = 1'b0;
      end
      if (idx_q == IdxW'(2)) begin
        case (kind_q)
          KIND_MEAS:     if (s1_byte_q != COUNT_MEAS) hdr_d = 1'b0;
          KIND_SETTINGS: if (s1_byte_q != COUNT_SETTINGS) hdr_d = 1'b0;
          KIND_FIRMWARE: if (s1_byte_q != COUNT_FIRMWARE) hdr_d = 1'b0;
          default: ;
        endcase
      end
      if (kind_q == KIND_ECHO && idx_q == IdxW'(3)) begin
        echo_d = {part_q, s1_byte_q};
      end
      if (slot.hit) begin
        words_d[slot.sel] = {part_q, s1_byte_q};
      end
      part_d = s1_byte_q;
      idx_d  = idx_q + IdxW'(1);
    end
  end

  always_comb begin
    case (kind_q)
      KIND_MEAS:     want_len = LEN_MEAS;
      KIND_SETTINGS: want_len = LEN_SETTINGS;
      KIND_FIRMWARE: want_len = LEN_FIRMWARE;
      default:       want_len = LEN_ECHO;
    endcase
    if (!hdr_d || idx_d != want_len) begin
      status_d = ST_FRAME;
    end else if (tail0_d != crc_d[7:0] || tail1_d != crc_d[15:8]) begin
      status_d = ST_CRC;
    end else if (kind_q == KIND_ECHO && echo_d != reg_q) begin
      status_d = ST_REG;
    end else begin
      status_d = ST_OK;
    end
    va_d = '0;
    vb_d = '0;
    vc_d = '0;
    vd_d = '0;
    if (status_d == ST_OK && kind_q != KIND_ECHO) begin
      va_d = words_d[0];
      if (kind_q != KIND_FIRMWARE) begin
        vb_d = words_d[1];
        vc_d = words_d[2];
      end
      if (kind_q == KIND_SETTINGS) begin
        vd_d = words_d[3];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= CRC_INIT;
      idx_q   <= '0;
      tail0_q <= '0;
      tail1_q <= '0;
      hdr_q   <= 1'b1;
      words_q <= '{default: '0};
      echo_q  <= '0;
      part_q  <= '0;
    end else if (s1_adv) begin
      if (s1_last_q) begin
        crc_q   <= CRC_INIT;
        idx_q   <= '0;
        tail0_q <= '0;
        tail1_q <= '0;
        hdr_q   <= 1'b1;
        words_q <= '{default: '0};
        echo_q  <= '0;
        part_q  <= '0;
      end else begin
        crc_q   <= crc_d;
        idx_q   <= idx_d;
        tail0_q <= tail0_d;
        tail1_q <= tail1_d;
        hdr_q   <= hdr_d;
        words_q <= words_d;
        echo_q  <= echo_d;
        part_q  <= part_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_last_q) begin
      status_q <= status_d;
      va_q     <= va_d;
      vb_q     <= vb_d;
      vc_q     <= vc_d;
      vd_q     <= vd_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.status  = status_q;
  assign out_o.value_a = va_q;
  assign out_o.value_b = vb_q;
  assign out_o.value_c = vc_q;
  assign out_o.value_d = vd_q;

`ifndef SYNTHESIS
  a_idx_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IdxW'(MAX_FRAME_BYTES))
    else $error("frame byte count beyond limit");

  a_crc_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q < IdxW'(3) |-> crc_q == CRC_INIT)
    else $error("crc folded before third byte");

  a_frame_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_last_q |=> idx_q == '0 && hdr_q && crc_q == CRC_INIT)
    else $error("frame state not cleared after last byte");

  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != ST_OK |->
      va_q == '0 && vb_q == '0 && vc_q == '0 && vd_q == '0)
    else $error("failed frame carries data words");

  a_result_waits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_last_q && out_valid_q && !out_o.ready |-> !in_i.ready)
    else $error("final byte overtook waiting result");
`endif

endmodule
